FILE: design/swg_pkg.sv
// Package for the stimulation waveform generator.
// Holds field widths, codes, the state type and the per-sample factor tables.
// No dependencies.
package swg_pkg;

  localparam int SAMPLES    = 64;
  localparam int IDX_W      = 6;
  localparam int CODE_W     = 16;
  localparam int LEN_W      = 7;
  localparam int PER_W      = 14;
  localparam int REP_W      = 23;
  localparam int CFG_W      = 16;
  localparam int APB_DW     = 32;
  localparam int ADDR_W     = 3;
  localparam int OP_W       = 16;
  localparam int DIG_W      = 4;
  localparam int MUL_STEPS  = OP_W / DIG_W;
  localparam int REP_NUM_W  = 2 * OP_W + 1;
  localparam int REP_DEN_W  = 10;

  localparam logic [PER_W-1:0]     PERIOD_NUM = PER_W'(1000000 / SAMPLES);
  localparam logic [PER_W-1:0]     DC_PERIOD  = PER_W'(1000);
  localparam logic [REP_NUM_W-1:0] REP_BIAS   = REP_NUM_W'(999);
  localparam logic [REP_DEN_W-1:0] REP_DIV    = REP_DEN_W'(1000);

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_NO_SPACE = 2'd2;

  localparam logic [1:0] WAVE_DC     = 2'd0;
  localparam logic [1:0] WAVE_SINE   = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_TRI    = 2'd3;

  localparam logic REG_STEP = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_TRI  = 2'd1;
  localparam logic [1:0] SH_SINE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_REP,
    ST_START,
    ST_MUL,
    ST_EMIT
  } swg_state_t;

  typedef struct packed {
    logic            neg;
    logic [OP_W-1:0] mag;
    logic [1:0]      sh;
  } factor_t;

  function automatic logic [14:0] quarter_sine(input logic [4:0] k);
    logic [14:0] v;
    case (k)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd3212;
      5'd2:  v = 15'd6393;
      5'd3:  v = 15'd9512;
      5'd4:  v = 15'd12540;
      5'd5:  v = 15'd15447;
      5'd6:  v = 15'd18205;
      5'd7:  v = 15'd20788;
      5'd8:  v = 15'd23170;
      5'd9:  v = 15'd25330;
      5'd10: v = 15'd27246;
      5'd11: v = 15'd28899;
      5'd12: v = 15'd30274;
      5'd13: v = 15'd31357;
      5'd14: v = 15'd32138;
      5'd15: v = 15'd32610;
      5'd16: v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  function automatic factor_t wave_factor(input logic [1:0] kind, input logic [IDX_W-1:0] idx);
    factor_t     f;
    logic [6:0]  i7;
    logic [6:0]  k7;
    logic [7:0]  q;
    logic [7:0]  d;
    i7 = {1'b0, idx};
    k7 = '0;
    q  = {idx, 2'b00};
    d  = '0;
    f.neg = 1'b0;
    f.mag = OP_W'(1);
    f.sh  = SH_NONE;
    case (kind)
      WAVE_SINE: begin
        f.sh = SH_SINE;
        if (i7 <= 7'd16) begin
          k7 = i7;
        end else if (i7 <= 7'd32) begin
          k7 = 7'd32 - i7;
        end else if (i7 <= 7'd48) begin
          k7 = i7 - 7'd32;
          f.neg = 1'b1;
        end else begin
          k7 = 7'd64 - i7;
          f.neg = 1'b1;
        end
        f.mag = OP_W'(quarter_sine(k7[4:0]));
      end
      WAVE_SQUARE: begin
        f.neg = (i7 >= 7'(SAMPLES / 2));
      end
      WAVE_TRI: begin
        f.sh = SH_TRI;
        if (q >= 8'd128) begin
          d = q - 8'd128;
        end else begin
          d = 8'd128 - q;
        end
        if (d <= 8'd64) begin
          f.mag = OP_W'(8'd64 - d);
        end else begin
          f.mag = OP_W'(d - 8'd64);
          f.neg = 1'b1;
        end
      end
      default: begin
        f.mag = OP_W'(1);
      end
    endcase
    return f;
  endfunction

endpackage

FILE: design/swg_req_if.sv
// Request channel of the waveform generator: valid, ready and request fields.
// No dependencies.
interface swg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  wave_kind;
  logic [15:0] wave_freq;
  logic [15:0] stim_span;
  logic [15:0] amp_level;
  logic        reverse_polarity;

  modport source (output valid, wave_kind, wave_freq, stim_span, amp_level,
                  reverse_polarity, input ready);
  modport sink (input valid, wave_kind, wave_freq, stim_span, amp_level,
                reverse_polarity, output ready);
endinterface

FILE: design/swg_res_if.sv
// Result channel of the waveform generator: valid, ready and result fields.
// No dependencies.
interface swg_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         sample_index;
  logic signed [15:0] sample_code;
  logic [6:0]         pattern_length;
  logic [13:0]        code_period;
  logic [22:0]        cycle_repeats;
  logic               last;

  modport source (output valid, status, sample_index, sample_code, pattern_length,
                  code_period, cycle_repeats, last, input ready);
  modport sink (input valid, status, sample_index, sample_code, pattern_length,
                code_period, cycle_repeats, last, output ready);
endinterface

FILE: design/swg_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Self-contained; the quotient holds until the next start.
module swg_sdiv #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt  = {num_r[NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule

FILE: design/swg_smul.sv
// Digit-serial shift-add multiplier, one multiplier digit per cycle.
// Depends on swg_pkg for operand and digit widths.
module swg_smul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [swg_pkg::OP_W-1:0]   a,
  input  logic [swg_pkg::OP_W-1:0]   b,
  output logic                       busy,
  output logic [2*swg_pkg::OP_W-1:0] prod
);

  localparam int OW    = swg_pkg::OP_W;
  localparam int DW    = swg_pkg::DIG_W;
  localparam int CNT_W = $clog2(swg_pkg::MUL_STEPS + 1);

  logic [OW-1:0]    a_r, a_nxt;
  logic [2*OW-1:0]  p_r, p_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [OW+DW-1:0] pp;
  logic [OW+DW-1:0] sum;

  assign pp  = a_r * p_r[DW-1:0];
  assign sum = {{DW{1'b0}}, p_r[2*OW-1:OW]} + pp;

  always_comb begin
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = a;
      p_nxt    = {{OW{1'b0}}, b};
      cnt_nxt  = CNT_W'(swg_pkg::MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt    = {sum, p_r[OW-1:DW]};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign busy = busy_r;
  assign prod = p_r;

endmodule

FILE: design/swg_cfg.sv
// APB-style register file: current step and buffer capacity.
// Depends on swg_pkg for widths and register indexes.
module swg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swg_pkg::ADDR_W-1:0]   paddr,
  input  logic [swg_pkg::APB_DW-1:0]   pwdata,
  output logic [swg_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [swg_pkg::CFG_W-1:0]    step,
  output logic [swg_pkg::CFG_W-1:0]    cap
);

  logic [swg_pkg::CFG_W-1:0] step_r, step_nxt;
  logic [swg_pkg::CFG_W-1:0] cap_r, cap_nxt;
  logic                      wr;

  assign wr = psel && penable && pwrite;

  always_comb begin
    step_nxt = step_r;
    cap_nxt  = cap_r;
    if (wr) begin
      case (paddr[2])
        swg_pkg::REG_STEP: step_nxt = pwdata[swg_pkg::CFG_W-1:0];
        swg_pkg::REG_CAP:  cap_nxt  = pwdata[swg_pkg::CFG_W-1:0];
        default: begin
          step_nxt = step_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= swg_pkg::CFG_W'(1);
      cap_r  <= swg_pkg::CFG_W'(swg_pkg::SAMPLES);
    end else begin
      step_r <= step_nxt;
      cap_r  <= cap_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      swg_pkg::REG_STEP: prdata = {{(swg_pkg::APB_DW-swg_pkg::CFG_W){1'b0}}, step_r};
      swg_pkg::REG_CAP:  prdata = {{(swg_pkg::APB_DW-swg_pkg::CFG_W){1'b0}}, cap_r};
      default:           prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign step   = step_r;
  assign cap    = cap_r;

endmodule

FILE: design/stimulation_waveform_generate_core.sv
// Top level of the stimulation waveform generator: sequencer, output register.
// Depends on swg_pkg, swg_req_if, swg_res_if, swg_sdiv, swg_smul and swg_cfg.
//
//   channel   direction  handshake           payload
//   in_ch     sink       valid/ready         wave_kind .. reverse_polarity
//   out_ch    source     valid/ready         status .. last
//   cfg_*     slave      psel/penable/pready current_step_ua, buffer_capacity
//
// A refused request skips the arithmetic and goes straight to ST_EMIT. Setup runs
// the amplitude and period divides and, for a periodic request, the 33-step
// bit-serial divide by 1000. Each code is then formed by the 4-digit serial
// multiplier, and output stalls can hold it.
// rst_n is synchronous, active low; no clearing pass follows it.
// A new request is taken while the final result still waits in the output register.
module stimulation_waveform_generate_core (
  input  logic                        clk,
  input  logic                        rst_n,
  swg_req_if.sink                     in_ch,
  swg_res_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [swg_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [swg_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [swg_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int OW = swg_pkg::OP_W;

  swg_pkg::swg_state_t state_r, state_nxt;

  logic [swg_pkg::CFG_W-1:0]     step_w, cap_w;
  logic [1:0]                    kind_r, kind_nxt;
  logic                          rev_r, rev_nxt;
  logic [15:0]                   dur_r, dur_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic [swg_pkg::IDX_W-1:0]     idx_r, idx_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [swg_pkg::IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [swg_pkg::CODE_W-1:0]    out_code_r, out_code_nxt;
  logic [swg_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  logic [swg_pkg::PER_W-1:0]     out_per_r, out_per_nxt;
  logic [swg_pkg::REP_W-1:0]     out_rep_r, out_rep_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          in_fire, load, err_w;
  logic [1:0]                    req_status;
  logic                          mul_start, dcode_start, dper_start, drep_start;
  logic                          mul_busy, dcode_busy, dper_busy, drep_busy;
  logic [OW-1:0]                 mul_a, mul_b;
  logic [2*OW-1:0]               prod;
  logic [15:0]                   q_code;
  logic [swg_pkg::PER_W-1:0]     q_per;
  logic [swg_pkg::REP_NUM_W-1:0] q_rep;
  logic [swg_pkg::REP_NUM_W-1:0] rep_num;
  logic [OW-1:0]                 code_mag_w;
  logic [swg_pkg::PER_W-1:0]     per_w;
  logic [swg_pkg::REP_W-1:0]     rep_w;
  swg_pkg::factor_t              fac_w;
  logic [2*OW:0]                 r_tri, r_sine;
  logic [16:0]                   rmag;
  logic                          neg_w;
  logic [swg_pkg::CODE_W-1:0]    code_w;
  logic                          last_w;
  logic                          is_dc;

  swg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .step    (step_w),
    .cap     (cap_w)
  );

  swg_sdiv #(.NUM_W(16), .DEN_W(16)) u_div_code (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dcode_start),
    .num   (in_ch.amp_level),
    .den   (step_w),
    .busy  (dcode_busy),
    .quo   (q_code)
  );

  swg_sdiv #(.NUM_W(14), .DEN_W(16)) u_div_per (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dper_start),
    .num   (swg_pkg::PERIOD_NUM),
    .den   (in_ch.wave_freq),
    .busy  (dper_busy),
    .quo   (q_per)
  );

  swg_sdiv #(.NUM_W(33), .DEN_W(10)) u_div_rep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (drep_start),
    .num   (rep_num),
    .den   (swg_pkg::REP_DIV),
    .busy  (drep_busy),
    .quo   (q_rep)
  );

  swg_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_dc   = (kind_r == swg_pkg::WAVE_DC);

  always_comb begin
    if (cap_w == '0 || in_ch.wave_freq == '0 || step_w == '0) begin
      req_status = swg_pkg::STAT_INVALID;
    end else if (in_ch.wave_kind != swg_pkg::WAVE_DC &&
                 cap_w < swg_pkg::CFG_W'(swg_pkg::SAMPLES)) begin
      req_status = swg_pkg::STAT_NO_SPACE;
    end else begin
      req_status = swg_pkg::STAT_OK;
    end
  end

  assign err_w = (req_status != swg_pkg::STAT_OK);

  assign code_mag_w = (q_code == '0) ? OW'(1) : q_code;
  assign per_w      = (q_per == '0) ? swg_pkg::PER_W'(1) : q_per;
  assign rep_w      = (q_rep[swg_pkg::REP_W-1:0] == '0) ? swg_pkg::REP_W'(1)
                                                        : q_rep[swg_pkg::REP_W-1:0];
  assign rep_num    = {1'b0, prod} + swg_pkg::REP_BIAS;
  assign fac_w      = swg_pkg::wave_factor(kind_r, idx_r);

  assign mul_a = (state_r == swg_pkg::ST_IDLE) ? in_ch.stim_span : code_mag_w;
  assign mul_b = (state_r == swg_pkg::ST_IDLE) ? in_ch.wave_freq : fac_w.mag;

  assign r_tri  = {1'b0, prod} + (2*OW+1)'(32);
  assign r_sine = {1'b0, prod} + (2*OW+1)'(16384);

  always_comb begin
    case (fac_w.sh)
      swg_pkg::SH_NONE: rmag = prod[16:0];
      swg_pkg::SH_TRI:  rmag = r_tri[22:6];
      swg_pkg::SH_SINE: rmag = r_sine[31:15];
      default:          rmag = prod[16:0];
    endcase
  end

  assign neg_w = rev_r ^ fac_w.neg;

  always_comb begin
    if (neg_w) begin
      if (rmag > 17'd32768) begin
        code_w = 16'h8000;
      end else begin
        code_w = 16'(~rmag + 17'd1);
      end
    end else begin
      if (rmag > 17'd32767) begin
        code_w = 16'h7FFF;
      end else begin
        code_w = rmag[15:0];
      end
    end
  end

  assign last_w = (status_r != swg_pkg::STAT_OK) || is_dc ||
                  (idx_r == swg_pkg::IDX_W'(swg_pkg::SAMPLES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swg_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = err_w ? swg_pkg::ST_EMIT : swg_pkg::ST_PREP;
        end
      end
      swg_pkg::ST_PREP: begin
        if (!mul_busy) begin
          state_nxt = swg_pkg::ST_REP;
        end
      end
      swg_pkg::ST_REP: begin
        if (!dcode_busy && !dper_busy && !drep_busy) begin
          state_nxt = swg_pkg::ST_START;
        end
      end
      swg_pkg::ST_START: begin
        state_nxt = swg_pkg::ST_MUL;
      end
      swg_pkg::ST_MUL: begin
        if (!mul_busy) begin
          state_nxt = swg_pkg::ST_EMIT;
        end
      end
      swg_pkg::ST_EMIT: begin
        if (load) begin
          state_nxt = last_w ? swg_pkg::ST_IDLE : swg_pkg::ST_START;
        end
      end
      default: begin
        state_nxt = swg_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    dcode_start = 1'b0;
    dper_start  = 1'b0;
    drep_start  = 1'b0;
    mul_start   = 1'b0;
    load        = 1'b0;
    case (state_r)
      swg_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        dcode_start = in_fire && !err_w;
        dper_start  = in_fire && !err_w;
        mul_start   = in_fire && !err_w;
      end
      swg_pkg::ST_PREP: begin
        drep_start = !mul_busy && !is_dc;
      end
      swg_pkg::ST_START: begin
        mul_start = 1'b1;
      end
      swg_pkg::ST_EMIT: begin
        load = !out_valid_r || out_ch.ready;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // request and result registers
  always_comb begin
    kind_nxt       = kind_r;
    rev_nxt        = rev_r;
    dur_nxt        = dur_r;
    status_nxt     = status_r;
    idx_nxt        = idx_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_code_nxt   = out_code_r;
    out_len_nxt    = out_len_r;
    out_per_nxt    = out_per_r;
    out_rep_nxt    = out_rep_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    if (in_fire) begin
      kind_nxt   = in_ch.wave_kind;
      rev_nxt    = in_ch.reverse_polarity;
      dur_nxt    = in_ch.stim_span;
      status_nxt = req_status;
      idx_nxt    = '0;
    end
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_last_nxt   = last_w;
      idx_nxt        = idx_r + 1'b1;
      if (status_r != swg_pkg::STAT_OK) begin
        out_idx_nxt  = '0;
        out_code_nxt = '0;
        out_len_nxt  = '0;
        out_per_nxt  = '0;
        out_rep_nxt  = '0;
      end else if (is_dc) begin
        out_idx_nxt  = '0;
        out_code_nxt = code_w;
        out_len_nxt  = swg_pkg::LEN_W'(1);
        out_per_nxt  = swg_pkg::DC_PERIOD;
        out_rep_nxt  = swg_pkg::REP_W'(dur_r);
      end else begin
        out_idx_nxt  = idx_r;
        out_code_nxt = code_w;
        out_len_nxt  = swg_pkg::LEN_W'(swg_pkg::SAMPLES);
        out_per_nxt  = per_w;
        out_rep_nxt  = rep_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    rev_r        <= rev_nxt;
    dur_r        <= dur_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_code_r   <= out_code_nxt;
    out_len_r    <= out_len_nxt;
    out_per_r    <= out_per_nxt;
    out_rep_r    <= out_rep_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.sample_index   = out_idx_r;
  assign out_ch.sample_code    = out_code_r;
  assign out_ch.pattern_length = out_len_r;
  assign out_ch.code_period    = out_per_r;
  assign out_ch.cycle_repeats  = out_rep_r;
  assign out_ch.last           = out_last_r;

`ifndef NO_ASSERTIONS
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swg_pkg::ST_IDLE) |-> !(mul_busy || dcode_busy || dper_busy || drep_busy))
    else $error("arithmetic unit busy while idle");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ch.ready) |-> $past(load && last_w))
    else $error("request port reopened before final result");

  a_mul_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swg_pkg::ST_MUL) |-> (status_r == swg_pkg::STAT_OK))
    else $error("sample product computed for a refused request");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && out_len_r == swg_pkg::LEN_W'(swg_pkg::SAMPLES))
      |-> (out_idx_r == swg_pkg::IDX_W'(swg_pkg::SAMPLES - 1)))
    else $error("last mark on a periodic code that is not the final one");
`endif

endmodule

FILE: dv/tb.sv
// Testbench for stimulation_waveform_generate_core: a directed request table, then random
// requests over several register settings, every result checked against the table's expected word or a local predictor.
// Depends on swg_pkg, swg_req_if, swg_res_if and the RTL of the generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [15:0] amp;
    logic        rev;
  } wave_req_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [swg_pkg::IDX_W-1:0]  idx;
    logic [swg_pkg::CODE_W-1:0] code;
    logic [swg_pkg::LEN_W-1:0]  len;
    logic [swg_pkg::PER_W-1:0]  period;
    logic [swg_pkg::REP_W-1:0]  rpt;
    logic                       last;
  } code_word_t;

  typedef struct {
    wave_req_t   req;
    logic [15:0] step;
    logic [15:0] cap;
    bit          typed;
    code_word_t  want;
  } table_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [swg_pkg::ADDR_W-1:0] cfg_paddr;
  logic [swg_pkg::APB_DW-1:0] cfg_pwdata;
  logic [swg_pkg::APB_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  swg_req_if in_ch();
  swg_res_if out_ch();

  stimulation_waveform_generate_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  logic [15:0] cur_step;
  logic [15:0] cur_cap;
  code_word_t  pending_codes[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          n_periodic = 0;
  int          n_dc = 0;
  int          n_refused = 0;
  int          n_settings = 0;
  int          stall_left = 0;
  bit          steady_out = 1'b0;
  bit          steady_in = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int sine_q15(input int i);
    int k;
    int mag;
    k = (i <= 16) ? i : (i <= 32) ? 32 - i : (i <= 48) ? i - 32 : 64 - i;
    case (k)
      0:  mag = 0;
      1:  mag = 3212;
      2:  mag = 6393;
      3:  mag = 9512;
      4:  mag = 12540;
      5:  mag = 15447;
      6:  mag = 18205;
      7:  mag = 20788;
      8:  mag = 23170;
      9:  mag = 25330;
      10: mag = 27246;
      11: mag = 28899;
      12: mag = 30274;
      13: mag = 31357;
      14: mag = 32138;
      15: mag = 32610;
      default: mag = 32767;
    endcase
    return (i > 32) ? -mag : mag;
  endfunction

  function automatic longint round_half_away(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [swg_pkg::CODE_W-1:0] clamp_code(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return swg_pkg::CODE_W'(v);
  endfunction

  function automatic string show_word(input code_word_t w);
    return $sformatf("status=%0d idx=%0d code=%0d len=%0d period=%0d repeat=%0d last=%0d",
                     w.status, w.idx, $signed(w.code), w.len, w.period, w.rpt, w.last);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic predict_pattern(input wave_req_t r);
    code_word_t     w;
    longint         code;
    longint         v;
    longint         d;
    int unsigned    period;
    longint unsigned rpt;
    w = '0;
    w.last = 1'b1;
    if (cur_cap == 0 || r.freq == 0 || cur_step == 0) begin
      w.status = swg_pkg::STAT_INVALID;
      pending_codes.push_back(w);
      n_refused++;
      return;
    end
    if (r.kind != swg_pkg::WAVE_DC && cur_cap < swg_pkg::SAMPLES) begin
      w.status = swg_pkg::STAT_NO_SPACE;
      pending_codes.push_back(w);
      n_refused++;
      return;
    end
    code = longint'(r.amp / cur_step);
    if (code <= 0) code = 1;
    if (r.rev) code = -code;
    w.status = swg_pkg::STAT_OK;
    if (r.kind == swg_pkg::WAVE_DC) begin
      w.code = clamp_code(code);
      w.len = swg_pkg::LEN_W'(1);
      w.period = swg_pkg::PER_W'(1000);
      w.rpt = swg_pkg::REP_W'(r.dur);
      pending_codes.push_back(w);
      n_dc++;
      return;
    end
    period = 32'd1000000 / ({16'd0, r.freq} * 32'd64);
    if (period == 0) period = 1;
    rpt = ({48'd0, r.dur} * {48'd0, r.freq} + 64'd999) / 64'd1000;
    if (rpt == 0) rpt = 1;
    for (int i = 0; i < swg_pkg::SAMPLES; i++) begin
      case (r.kind)
        swg_pkg::WAVE_SINE:   v = round_half_away(code * sine_q15(i), 32768);
        swg_pkg::WAVE_SQUARE: v = (i < swg_pkg::SAMPLES / 2) ? code : -code;
        default: begin
          d = 4 * i - 2 * swg_pkg::SAMPLES;
          if (d < 0) d = -d;
          v = round_half_away(code * (swg_pkg::SAMPLES - d), swg_pkg::SAMPLES);
        end
      endcase
      w.idx = swg_pkg::IDX_W'(i);
      w.code = clamp_code(v);
      w.len = swg_pkg::LEN_W'(swg_pkg::SAMPLES);
      w.period = swg_pkg::PER_W'(period);
      w.rpt = swg_pkg::REP_W'(rpt);
      w.last = (i == swg_pkg::SAMPLES - 1);
      pending_codes.push_back(w);
    end
    n_periodic++;
  endtask

  function automatic int pick_gap();
    int r;
    if (steady_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic wave_req_t random_request();
    wave_req_t r;
    r.kind = ($urandom_range(0, 4) == 0) ? swg_pkg::WAVE_DC : 2'($urandom_range(1, 3));
    case ($urandom_range(0, 15))
      0:          r.freq = '0;
      1:          r.freq = 16'd1;
      2:          r.freq = '1;
      3, 4, 5, 6: r.freq = 16'($urandom_range(1, 1000));
      default:    r.freq = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       r.dur = '0;
      1:       r.dur = '1;
      2, 3:    r.dur = 16'($urandom_range(1, 50));
      default: r.dur = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       r.amp = '0;
      1:       r.amp = '1;
      2, 3, 4: r.amp = 16'($urandom_range(1, 2000));
      default: r.amp = 16'($urandom);
    endcase
    r.rev = 1'($urandom);
    return r;
  endfunction

  function automatic table_row_t make_row(input logic [1:0] kind, input int freq, dur, amp,
                                          input bit rev, input int step, cap, input bit typed,
                                          input logic [1:0] status, input int code, len,
                                          period, rpt);
    table_row_t row;
    row.req = {kind, 16'(freq), 16'(dur), 16'(amp), rev};
    row.step = 16'(step);
    row.cap = 16'(cap);
    row.typed = typed;
    row.want = {status, swg_pkg::IDX_W'(0), swg_pkg::CODE_W'(code), swg_pkg::LEN_W'(len),
                swg_pkg::PER_W'(period), swg_pkg::REP_W'(rpt), 1'b1};
    return row;
  endfunction

  task automatic send_request(input wave_req_t r, input bit typed, input code_word_t want);
    int gap;
    in_ch.valid            <= 1'b1;
    in_ch.wave_kind        <= r.kind;
    in_ch.wave_freq        <= r.freq;
    in_ch.stim_span        <= r.dur;
    in_ch.amp_level        <= r.amp;
    in_ch.reverse_polarity <= r.rev;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (typed) begin
      pending_codes.push_back(want);
      if (want.status != swg_pkg::STAT_OK) n_refused++;
      else n_dc++;
    end else begin
      predict_pattern(r);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_codes.size() != 0);
  endtask

  task automatic cfg_read(input logic idx, input logic [15:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= swg_pkg::ADDR_W'({idx, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata[swg_pkg::CFG_W-1:0] !== want)
      flag_mismatch($sformatf("register %0d read expected %0d got %0d", idx, want,
                              cfg_prdata[swg_pkg::CFG_W-1:0]));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= swg_pkg::ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (idx == swg_pkg::REG_STEP) cur_step = value;
    else cur_cap = value;
    cfg_read(idx, value);
  endtask

  always @(posedge clk) begin
    code_word_t got;
    code_word_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.status, out_ch.sample_index, out_ch.sample_code, out_ch.pattern_length,
             out_ch.code_period, out_ch.cycle_repeats, out_ch.last};
      results_seen++;
      if (pending_codes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %s", show_word(got)));
      end else begin
        want = pending_codes.pop_front();
        if (got !== want)
          flag_mismatch($sformatf("expected %s, got %s", show_word(want), show_word(got)));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!steady_out && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
    if ($urandom_range(0, 399) == 0) steady_out = !steady_out;
  end

  initial begin
    table_row_t  rows[$];
    logic [15:0] ph_step;
    logic [15:0] ph_cap;
    int          ph_count;
    rst_n                  = 1'b0;
    cfg_psel               = 1'b0;
    cfg_penable            = 1'b0;
    cfg_pwrite             = 1'b0;
    cfg_paddr              = '0;
    cfg_pwdata             = '0;
    in_ch.valid            = 1'b0;
    in_ch.wave_kind        = swg_pkg::WAVE_DC;
    in_ch.wave_freq        = '0;
    in_ch.stim_span        = '0;
    in_ch.amp_level        = '0;
    in_ch.reverse_polarity = 1'b0;
    cur_step               = 16'd1;
    cur_cap                = 16'd64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read(swg_pkg::REG_STEP, 16'd1);
    cfg_read(swg_pkg::REG_CAP, 16'd64);

    rows.push_back(make_row(swg_pkg::WAVE_DC, 1000, 7, 5, 0, 1, 64, 1,
                            swg_pkg::STAT_OK, 5, 1, 1000, 7));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 1, 0, 0, 1, 1, 64, 1,
                            swg_pkg::STAT_OK, -1, 1, 1000, 0));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 65535, 65535, 65535, 0, 1, 64, 1,
                            swg_pkg::STAT_OK, 32767, 1, 1000, 65535));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 2, 40, 65535, 1, 1, 64, 1,
                            swg_pkg::STAT_OK, -32768, 1, 1000, 40));
    rows.push_back(make_row(swg_pkg::WAVE_SINE, 1, 0, 1000, 0, 1, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SINE, 65535, 65535, 65535, 1, 1, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SQUARE, 50, 1000, 200, 0, 1, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SQUARE, 16, 16, 65535, 0, 1, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_TRI, 130, 1, 65535, 0, 1, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_TRI, 977, 333, 300, 1, 1, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 0, 100, 50, 0, 1, 64, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SINE, 0, 100, 50, 1, 1, 64, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 10, 5, 5, 0, 0, 64, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SQUARE, 10, 5, 5, 0, 0, 64, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 10, 5, 5, 0, 1, 0, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_TRI, 10, 5, 5, 1, 1, 0, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SINE, 10, 5, 5, 0, 1, 63, 1,
                            swg_pkg::STAT_NO_SPACE, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_TRI, 10, 5, 5, 1, 1, 63, 1,
                            swg_pkg::STAT_NO_SPACE, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 10, 3, 9, 0, 1, 63, 1,
                            swg_pkg::STAT_OK, 9, 1, 1000, 3));
    rows.push_back(make_row(swg_pkg::WAVE_SQUARE, 0, 3, 9, 0, 1, 63, 1,
                            swg_pkg::STAT_INVALID, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_DC, 4, 12, 100, 0, 65535, 65535, 1,
                            swg_pkg::STAT_OK, 1, 1, 1000, 12));
    rows.push_back(make_row(swg_pkg::WAVE_SINE, 440, 250, 65535, 0, 65535, 65535, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_SQUARE, 1000, 2, 65535, 1, 7, 64, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));
    rows.push_back(make_row(swg_pkg::WAVE_TRI, 15625, 65535, 12345, 0, 1000, 65535, 0,
                            swg_pkg::STAT_OK, 0, 0, 0, 0));

    foreach (rows[n]) begin
      if (rows[n].step != cur_step || rows[n].cap != cur_cap) begin
        wait_idle();
        if (rows[n].step != cur_step) cfg_write(swg_pkg::REG_STEP, rows[n].step);
        if (rows[n].cap != cur_cap) cfg_write(swg_pkg::REG_CAP, rows[n].cap);
        n_settings++;
      end
      send_request(rows[n].req, rows[n].typed, rows[n].want);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin ph_step = 16'd1;     ph_cap = 16'hFFFF; ph_count = 90; end
        1: begin ph_step = 16'd13;    ph_cap = 16'd64;   ph_count = 80; end
        2: begin ph_step = 16'hFFFF;  ph_cap = 16'd64;   ph_count = 50; end
        3: begin ph_step = 16'd0;     ph_cap = 16'd100;  ph_count = 20; end
        4: begin ph_step = 16'd250;   ph_cap = 16'd0;    ph_count = 20; end
        5: begin ph_step = 16'd3;     ph_cap = 16'd63;   ph_count = 40; end
        6: begin
          ph_step = 16'($urandom_range(1, 400));
          ph_cap = 16'($urandom_range(64, 65535));
          ph_count = 90;
        end
        default: begin ph_step = 16'd1; ph_cap = 16'd64; ph_count = 68; end
      endcase
      wait_idle();
      cfg_write(swg_pkg::REG_STEP, ph_step);
      cfg_write(swg_pkg::REG_CAP, ph_cap);
      n_settings++;
      steady_in = ($urandom_range(0, 3) == 0);
      repeat (ph_count) begin
        if ($urandom_range(0, 39) == 0) wait_idle();
        send_request(random_request(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    $display("Covered %0d periodic, %0d DC and %0d refused requests over %0d settings;",
             n_periodic, n_dc, n_refused, n_settings);
    $display("%0d results checked, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: stimulation_waveform_generate_core.f
design/swg_pkg.sv
design/swg_req_if.sv
design/swg_res_if.sv
design/swg_sdiv.sv
design/swg_smul.sv
design/swg_cfg.sv
design/stimulation_waveform_generate_core.sv
dv/tb.sv
